@@ rtl/core/ialu_pkg.sv @@
package ialu_pkg;

   localparam int OP_WIDTH = 3;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD  = 3'd0,
      OP_ADDI = 3'd1,
      OP_SUB  = 3'd2,
      OP_MULU = 3'd3,
      OP_DIVU = 3'd4,
      OP_REMU = 3'd5,
      OP_NOP6 = 3'd6,
      OP_NOP7 = 3'd7
   } op_type;

   // Classification made by the front end
   typedef enum logic [1:0] {
      CLS_FAST = 2'd0,
      CLS_MUL  = 2'd1,
      CLS_DIV  = 2'd2,
      CLS_ZERO = 2'd3
   } cls_type;

endpackage

@@ rtl/core/ialu_if.sv @@
interface ialu_req_if #(parameter int DATA_WIDTH = 64);
   logic                  valid;
   logic                  ready;
   logic [2:0]            operation;
   logic [DATA_WIDTH-1:0] operand_a;
   logic [DATA_WIDTH-1:0] operand_b;
   modport source (output valid, operation, operand_a, operand_b, input ready);
   modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface ialu_rsp_if #(parameter int DATA_WIDTH = 64);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] result_value;
   logic                  exception;
   modport source (output valid, result_value, exception, input ready);
   modport sink   (input valid, result_value, exception, output ready);
endinterface

@@ rtl/core/ialu_front.sv @@
// Front end: accepts requests, classifies and registers them
module ialu_front #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [2:0]              in_op,
   input  logic [DATA_WIDTH-1:0]   in_a,
   input  logic [DATA_WIDTH-1:0]   in_b,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ialu_pkg::cls_type       out_cls,
   output logic [2:0]              out_op,
   output logic [DATA_WIDTH-1:0]   out_a,
   output logic [DATA_WIDTH-1:0]   out_b
);
   import ialu_pkg::*;

   logic                  valid_ff, valid_in;
   cls_type               cls_ff, cls_in;
   logic [2:0]            op_ff;
   logic [DATA_WIDTH-1:0] a_ff, b_ff;

   assign in_ready = !valid_ff || out_ready;

   // Classify by operation
   always_comb begin
      unique case (op_type'(in_op))
         OP_ADD, OP_ADDI, OP_SUB: cls_in = CLS_FAST;
         OP_MULU:                 cls_in = CLS_MUL;
         OP_DIVU, OP_REMU:        cls_in = CLS_DIV;
         default:                 cls_in = CLS_ZERO;
      endcase
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cls_ff <= cls_in;
         op_ff  <= in_op;
         a_ff   <= in_a;
         b_ff   <= in_b;
      end
   end

   assign out_valid = valid_ff;
   assign out_cls   = cls_ff;
   assign out_op    = op_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
endmodule

@@ rtl/core/ialu_fifo.sv @@
// Short queue between front and back ends
module ialu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = cnt_ff != (PTR_W+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end
endmodule

@@ rtl/core/ialu_back.sv @@
// Back end: add/sub, multiply from registered partial products, radix-2 divider
module ialu_back #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ialu_pkg::cls_type       in_cls,
   input  logic [2:0]              in_op,
   input  logic [DATA_WIDTH-1:0]   in_a,
   input  logic [DATA_WIDTH-1:0]   in_b,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [DATA_WIDTH-1:0]   out_value,
   output logic                    out_exc
);
   import ialu_pkg::*;

   localparam int HW    = DATA_WIDTH / 2;
   localparam int LW    = DATA_WIDTH - HW;
   localparam int CNT_W = $clog2(DATA_WIDTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic                  take;
   logic                  res_valid_ff, res_valid_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic                  exc_ff, exc_in;
   logic                  load;

   // Multiply: three partial products registered, then summed
   logic [DATA_WIDTH-1:0] pll_ff, plh_ff, phl_ff;
   logic [DATA_WIDTH-1:0] mul_sum;

   // Divider datapath
   logic [DATA_WIDTH-1:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff;
   logic                  is_rem_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_WIDTH:0]   trial;

   assign load     = !res_valid_ff || out_ready;
   assign in_ready = (state_ff == ST_IDLE) && load;
   assign take     = in_valid && in_ready;

   always_comb begin
      mul_sum = pll_ff + (plh_ff << LW) + (phl_ff << LW);
   end

   // Restoring division step
   always_comb begin
      trial = {rem_ff, quo_ff[DATA_WIDTH-1]} - {1'b0, dvs_ff};
      quo_in = {quo_ff[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
      if (trial[DATA_WIDTH]) begin
         rem_in = {rem_ff[DATA_WIDTH-2:0], quo_ff[DATA_WIDTH-1]};
      end else begin
         rem_in = trial[DATA_WIDTH-1:0];
      end
      cnt_in = cnt_ff - 1'b1;
   end

   // Control and result register
   always_comb begin
      state_in     = state_ff;
      res_valid_in = res_valid_ff && !out_ready;
      res_in       = res_ff;
      exc_in       = exc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (in_cls)
                  CLS_FAST: begin
                     res_valid_in = 1'b1;
                     exc_in       = 1'b0;
                     res_in       = (op_type'(in_op) == OP_SUB) ? in_a - in_b : in_a + in_b;
                  end
                  CLS_MUL: state_in = ST_MUL;
                  CLS_DIV: begin
                     if (in_b == '0) begin
                        res_valid_in = 1'b1;
                        exc_in       = 1'b1;
                        res_in       = '0;
                     end else begin
                        state_in = ST_DIV;
                     end
                  end
                  default: begin
                     res_valid_in = 1'b1;
                     exc_in       = 1'b0;
                     res_in       = '0;
                  end
               endcase
            end
         end
         ST_MUL: state_in = ST_DONE;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               res_valid_in = 1'b1;
               exc_in       = 1'b0;
               state_in     = ST_IDLE;
               if (is_rem_ff) begin
                  res_in = rem_ff;
               end else if (cnt_ff == '0 && dvs_ff != '0) begin
                  res_in = quo_ff;
               end else begin
                  res_in = mul_sum;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      exc_ff <= exc_in;
      if (take) begin
         pll_ff    <= DATA_WIDTH'({{HW{1'b0}}, in_a[LW-1:0]} * {{HW{1'b0}}, in_b[LW-1:0]});
         plh_ff    <= DATA_WIDTH'({{HW{1'b0}}, in_a[LW-1:0]}
                                  * {{LW{1'b0}}, in_b[DATA_WIDTH-1:LW]});
         phl_ff    <= DATA_WIDTH'({{LW{1'b0}}, in_a[DATA_WIDTH-1:LW]}
                                  * {{HW{1'b0}}, in_b[LW-1:0]});
         quo_ff    <= in_a;
         rem_ff    <= '0;
         is_rem_ff <= (op_type'(in_op) == OP_REMU) && (in_cls == CLS_DIV);
         dvs_ff    <= (in_cls == CLS_DIV) ? in_b : '0;
         cnt_ff    <= (in_cls == CLS_DIV) ? CNT_W'(DATA_WIDTH) : '0;
      end else if (state_ff == ST_DIV) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_value = res_ff;
   assign out_exc   = exc_ff;
endmodule

@@ rtl/core/integer_alu_with_div_exception.sv @@
// Integer execute unit: add, add-immediate, subtract, low half of unsigned
// multiply, unsigned divide and remainder on DATA_WIDTH-bit operands.
// Requests enter a registered front end and a two-entry queue, so the
// request side keeps moving while the back end is busy, until the queue
// fills. Add, subtract, zero-divisor and unused codes finish in the back
// end straight from idle, giving one result per cycle while the output is
// not stalled. Multiply registers its partial products, then sums them.
// Divide and remainder use the one-bit-per-cycle restoring divider. A zero
// divisor returns 0 with the exception flag set; every other op clears it.
module integer_alu_with_div_exception #(
   parameter int DATA_WIDTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   ialu_req_if.sink   req,
   ialu_rsp_if.source rsp
);
   import ialu_pkg::*;

   localparam int QW = 2 + 3 + 2 * DATA_WIDTH;

   logic                  f_valid, f_ready;
   cls_type               f_cls;
   logic [2:0]            f_op;
   logic [DATA_WIDTH-1:0] f_a, f_b;
   logic                  q_valid, q_ready;
   logic [QW-1:0]         q_data;

   ialu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_op     (req.operation),
      .in_a      (req.operand_a),
      .in_b      (req.operand_b),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_cls   (f_cls),
      .out_op    (f_op),
      .out_a     (f_a),
      .out_b     (f_b)
   );

   ialu_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_cls, f_op, f_a, f_b}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   ialu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_cls    (cls_type'(q_data[QW-1 -: 2])),
      .in_op     (q_data[QW-3 -: 3]),
      .in_a      (q_data[2*DATA_WIDTH-1 -: DATA_WIDTH]),
      .in_b      (q_data[DATA_WIDTH-1:0]),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_value (rsp.result_value),
      .out_exc   (rsp.exception)
   );

   // Exception only ever accompanies a zero result
   a_exc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.exception |-> rsp.result_value == '0)
      else $error("exception with non-zero result");

   // Stalled result must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_value)
                                   && $stable(rsp.exception))
      else $error("stalled result changed");

   // Front end keeps its item while the queue is full
   a_q_flow: assert property (@(posedge clock) disable iff (reset)
      f_valid && !f_ready |=> f_valid)
      else $error("front item dropped");
endmodule
